// File: design/e131_pkt_pkg.sv
package e131_pkt_pkg;

  localparam int HDR_BYTES = 126;
  localparam logic [15:0] FLAGS_HI = 16'h7000;

  localparam logic [2:0] OP_WRITE_SLOT = 3'd0;
  localparam logic [2:0] OP_WRITE_PAIR = 3'd1;
  localparam logic [2:0] OP_CLEAR      = 3'd2;
  localparam logic [2:0] OP_ADV_SEQ    = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  localparam logic [2:0] REG_UNIVERSE = 3'd0;
  localparam logic [2:0] REG_PRIORITY = 3'd1;
  localparam logic [2:0] REG_START    = 3'd2;
  localparam logic [2:0] REG_SLOTS    = 3'd3;
  localparam logic [2:0] REG_PREVIEW  = 3'd4;

  localparam logic [15:0] RST_UNIVERSE = 16'd1;
  localparam logic [7:0]  RST_PRIORITY = 8'd100;
  localparam logic [7:0]  RST_START    = 8'd0;
  localparam logic [9:0]  RST_SLOTS    = 10'd512;

  localparam logic [7:0] PREAMBLE [16] = '{
    8'h00, 8'h10, 8'h00, 8'h00, 8'h41, 8'h53, 8'h43, 8'h2d,
    8'h45, 8'h31, 8'h2e, 8'h31, 8'h37, 8'h00, 8'h00, 8'h00
  };

  typedef enum logic [2:0] {
    K_WRITE1,
    K_WRITE2,
    K_CLEAR,
    K_SEQ,
    K_RDHDR,
    K_RDSLOT,
    K_REJECT
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [9:0]  addr;
    logic [15:0] wdata;
    logic [6:0]  hoff;
    logic [9:0]  plen;
  } cmd_t;

  typedef struct packed {
    logic [15:0] universe;
    logic [7:0]  priority_level;
    logic [7:0]  start_code;
    logic [9:0]  slot_count;
    logic        preview;
  } cfg_t;

  function automatic logic [7:0] hdr_byte(input logic [6:0] off, input logic [9:0] n,
                                          input cfg_t cfg, input logic [7:0] seq);
    logic [15:0] root_len;
    logic [15:0] frame_len;
    logic [15:0] dmp_len;
    logic [15:0] prop_cnt;
    logic [7:0]  b;
    root_len  = {6'd0, n + 10'd110} | FLAGS_HI;
    frame_len = {6'd0, n + 10'd88} | FLAGS_HI;
    dmp_len   = {6'd0, n + 10'd11} | FLAGS_HI;
    prop_cnt  = {6'd0, n + 10'd1};
    b = 8'h00;
    if (off < 7'd16) begin
      b = PREAMBLE[off[3:0]];
    end else begin
      case (off)
        7'd16:  b = root_len[15:8];
        7'd17:  b = root_len[7:0];
        7'd21:  b = 8'h04;
        7'd38:  b = frame_len[15:8];
        7'd39:  b = frame_len[7:0];
        7'd43:  b = 8'h02;
        7'd108: b = cfg.priority_level;
        7'd111: b = seq;
        7'd112: b = {1'b0, cfg.preview, 6'd0};
        7'd113: b = cfg.universe[15:8];
        7'd114: b = cfg.universe[7:0];
        7'd115: b = dmp_len[15:8];
        7'd116: b = dmp_len[7:0];
        7'd117: b = 8'h02;
        7'd118: b = 8'ha1;
        7'd122: b = 8'h01;
        7'd123: b = prop_cnt[15:8];
        7'd124: b = prop_cnt[7:0];
        7'd125: b = cfg.start_code;
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

// File: design/e131_pkt_front.sv
module e131_pkt_front (
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [2:0]            op,
  input  logic [9:0]            slot_number,
  input  logic [15:0]           write_value,
  input  logic [9:0]            byte_offset,
  input  logic [9:0]            n_slots,
  input  logic                  busy,
  input  logic                  q_full,
  output logic                  q_push,
  output e131_pkt_pkg::cmd_t    q_cmd
);

  localparam logic [9:0] HDR_W = 10'(e131_pkt_pkg::HDR_BYTES);

  logic [9:0] plen;

  assign plen     = n_slots + HDR_W;
  assign s_tready = !q_full && !busy;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    q_cmd       = '0;
    q_cmd.kind  = e131_pkt_pkg::K_REJECT;
    q_cmd.wdata = write_value;
    q_cmd.hoff  = byte_offset[6:0];
    q_cmd.plen  = plen;
    unique case (op)
      e131_pkt_pkg::OP_WRITE_SLOT: begin
        q_cmd.addr = slot_number - 10'd1;
        if (slot_number != 10'd0 && slot_number <= n_slots) begin
          q_cmd.kind = e131_pkt_pkg::K_WRITE1;
        end
      end
      e131_pkt_pkg::OP_WRITE_PAIR: begin
        q_cmd.addr = slot_number - 10'd1;
        if (slot_number != 10'd0 && slot_number < n_slots) begin
          q_cmd.kind = e131_pkt_pkg::K_WRITE2;
        end
      end
      e131_pkt_pkg::OP_CLEAR:   q_cmd.kind = e131_pkt_pkg::K_CLEAR;
      e131_pkt_pkg::OP_ADV_SEQ: q_cmd.kind = e131_pkt_pkg::K_SEQ;
      e131_pkt_pkg::OP_READ: begin
        q_cmd.addr = byte_offset - HDR_W;
        if (byte_offset < HDR_W) begin
          q_cmd.kind = e131_pkt_pkg::K_RDHDR;
        end else if (byte_offset < plen) begin
          q_cmd.kind = e131_pkt_pkg::K_RDSLOT;
        end
      end
      default: q_cmd.kind = e131_pkt_pkg::K_REJECT;
    endcase
  end

endmodule

// File: design/e131_pkt_cmdq.sv
module e131_pkt_cmdq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  e131_pkt_pkg::cmd_t push_cmd,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output e131_pkt_pkg::cmd_t head
);

  e131_pkt_pkg::cmd_t entry [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign valid = count != 2'd0;
  assign head  = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: design/e131_pkt_back.sv
module e131_pkt_back #(
  parameter int MAX_SLOTS = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  e131_pkt_pkg::cfg_t cfg,
  input  logic [9:0]         n_slots,
  input  logic               q_valid,
  input  e131_pkt_pkg::cmd_t q_head,
  output logic               q_pop,
  output logic               busy,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         read_byte,
  output logic               status,
  output logic [9:0]         packet_length
);

  localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SLOTS - 1);

  typedef enum logic [3:0] {
    ST_SWEEP = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_WR2   = 4'b1000
  } state_t;

  logic [7:0] mem [MAX_SLOTS];

  state_t        state;
  state_t        state_next;
  logic [AW-1:0] sweep_addr;
  logic [7:0]    seq;
  logic [AW-1:0] wr2_addr;
  logic [7:0]    wr2_data;
  logic [9:0]    rd_plen;
  logic [7:0]    mem_rdata;

  logic          out_free;
  logic          emit_now;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    hdr;

  assign busy     = state == ST_SWEEP;
  assign out_free = !m_tvalid || m_tready;
  assign q_pop    = state == ST_EXEC && q_valid && out_free;
  assign emit_now = q_pop && q_head.kind != e131_pkt_pkg::K_RDSLOT;
  assign hdr      = e131_pkt_pkg::hdr_byte(q_head.hoff, n_slots, cfg, seq);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_addr;
    mem_wdata = 8'h00;
    state_next = state;
    unique case (state)
      ST_SWEEP: begin
        mem_we = 1'b1;
        if (sweep_addr == LAST_ADDR) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (q_pop) begin
          case (q_head.kind)
            e131_pkt_pkg::K_WRITE1: begin
              mem_we    = 1'b1;
              mem_waddr = q_head.addr[AW-1:0];
              mem_wdata = q_head.wdata[7:0];
            end
            e131_pkt_pkg::K_WRITE2: begin
              mem_we     = 1'b1;
              mem_waddr  = q_head.addr[AW-1:0];
              mem_wdata  = q_head.wdata[15:8];
              state_next = ST_WR2;
            end
            e131_pkt_pkg::K_CLEAR:  state_next = ST_SWEEP;
            e131_pkt_pkg::K_RDSLOT: state_next = ST_READ;
            default: ;
          endcase
        end
      end
      ST_READ: state_next = ST_EXEC;
      ST_WR2: begin
        mem_we     = 1'b1;
        mem_waddr  = wr2_addr;
        mem_wdata  = wr2_data;
        state_next = ST_EXEC;
      end
      default: state_next = ST_EXEC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (q_pop && q_head.kind == e131_pkt_pkg::K_RDSLOT) begin
      mem_rdata <= mem[q_head.addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      seq        <= 8'd0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) begin
        sweep_addr <= sweep_addr + AW'(1);
      end else begin
        sweep_addr <= '0;
      end
      if (q_pop && q_head.kind == e131_pkt_pkg::K_SEQ) begin
        seq <= seq + 8'd1;
      end
      if (emit_now || state == ST_READ) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      wr2_addr <= q_head.addr[AW-1:0] + AW'(1);
      wr2_data <= q_head.wdata[7:0];
      rd_plen  <= q_head.plen;
    end
    if (emit_now) begin
      read_byte     <= (q_head.kind == e131_pkt_pkg::K_RDHDR) ? hdr : 8'h00;
      status        <= q_head.kind == e131_pkt_pkg::K_REJECT;
      packet_length <= q_head.plen;
    end else if (state == ST_READ) begin
      read_byte     <= mem_rdata;
      status        <= 1'b0;
      packet_length <= rd_plen;
    end
  end

endmodule

// File: design/e131_packet_buffer_framer_top.sv
// E1.31 data packet framer: holds one sACN data packet, a 126-byte header built
// from the APB registers followed by up to MAX_SLOTS DMX slot bytes in a
// single-port slot memory. Each request on the slave stream gives exactly one
// response on the master stream, in order. A front stage classifies requests
// into a two-entry command queue; the back end executes them against the slot
// memory. Slot writes, sequence advances, rejected requests and header reads
// are each handled in the execute state alone; a 16-bit pair write makes two
// writes on the one memory write port, and a slot read passes through a
// registered memory read. A clear request zeros the memory one slot per cycle,
// and after reset the same clearing pass runs; during either pass s_tready
// stays low. Registers may be written only while the block is idle.
module e131_packet_buffer_framer_top #(
  parameter int MAX_SLOTS = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] op, [12:3] slot_number, [28:13] write_value, [38:29] byte_offset
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] read_byte, [8] status, [18:9] packet_length
  output logic [23:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [9:0] MAX_W = 10'(MAX_SLOTS);

  e131_pkt_pkg::cfg_t cfg;
  e131_pkt_pkg::cmd_t push_cmd;
  e131_pkt_pkg::cmd_t head;

  logic [9:0] n_slots;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  logic       busy;
  logic [7:0] read_byte;
  logic       status;
  logic [9:0] packet_length;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.universe       <= e131_pkt_pkg::RST_UNIVERSE;
      cfg.priority_level <= e131_pkt_pkg::RST_PRIORITY;
      cfg.start_code     <= e131_pkt_pkg::RST_START;
      cfg.slot_count     <= e131_pkt_pkg::RST_SLOTS;
      cfg.preview        <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        e131_pkt_pkg::REG_UNIVERSE: cfg.universe       <= pwdata[15:0];
        e131_pkt_pkg::REG_PRIORITY: cfg.priority_level <= pwdata[7:0];
        e131_pkt_pkg::REG_START:    cfg.start_code     <= pwdata[7:0];
        e131_pkt_pkg::REG_SLOTS:    cfg.slot_count     <= pwdata[9:0];
        e131_pkt_pkg::REG_PREVIEW:  cfg.preview        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      e131_pkt_pkg::REG_UNIVERSE: prdata = {16'd0, cfg.universe};
      e131_pkt_pkg::REG_PRIORITY: prdata = {24'd0, cfg.priority_level};
      e131_pkt_pkg::REG_START:    prdata = {24'd0, cfg.start_code};
      e131_pkt_pkg::REG_SLOTS:    prdata = {22'd0, cfg.slot_count};
      e131_pkt_pkg::REG_PREVIEW:  prdata = {31'd0, cfg.preview};
      default:                    prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (cfg.slot_count == 10'd0) begin
      n_slots = 10'd1;
    end else if (cfg.slot_count > MAX_W) begin
      n_slots = MAX_W;
    end else begin
      n_slots = cfg.slot_count;
    end
  end

  e131_pkt_front u_front (
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .op          (s_tdata[2:0]),
    .slot_number (s_tdata[12:3]),
    .write_value (s_tdata[28:13]),
    .byte_offset (s_tdata[38:29]),
    .n_slots     (n_slots),
    .busy        (busy),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  e131_pkt_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head)
  );

  e131_pkt_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .n_slots       (n_slots),
    .q_valid       (q_valid),
    .q_head        (head),
    .q_pop         (q_pop),
    .busy          (busy),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .read_byte     (read_byte),
    .status        (status),
    .packet_length (packet_length)
  );

  assign m_tdata = {5'd0, packet_length, status, read_byte};

endmodule

// File: bench/tb_e131_packet_buffer_framer_top.sv
module tb_e131_packet_buffer_framer_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SLOTS = 512;
  localparam int HEADER_LEN = 126;
  localparam logic [15:0] LEN_FLAGS = 16'h7000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int CLEAR_SETTLE = 600;
  localparam int ITEMS_PER_PHASE = 210;
  localparam int CONFIG_PHASES = 6;

  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  localparam logic [7:0] ACN_PREAMBLE [16] = '{
    8'h00, 8'h10, 8'h00, 8'h00, 8'h41, 8'h53, 8'h43, 8'h2d,
    8'h45, 8'h31, 8'h2e, 8'h31, 8'h37, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [9:0]  byte_offset;
    logic [15:0] write_value;
    logic [9:0]  slot_number;
    logic [2:0]  op;
  } framer_req_t;

  typedef struct packed {
    logic [9:0] packet_length;
    logic       status;
    logic [7:0] read_byte;
  } framer_resp_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // [2:0] op, [12:3] slot_number, [28:13] write_value, [38:29] byte_offset
  logic [39:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  // [7:0] read_byte, [8] status, [18:9] packet_length
  logic [23:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  e131_packet_buffer_framer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  logic [15:0] universe_reg;
  logic [7:0]  priority_reg;
  logic [7:0]  start_code_reg;
  logic [9:0]  slot_count_reg;
  logic        preview_reg;
  logic [7:0]  slot_image [MAX_SLOTS];
  logic [7:0]  seq_count;

  framer_resp_t awaited [$];
  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int carried_slots();
    if (slot_count_reg == 10'd0) return 1;
    if (slot_count_reg > 10'(MAX_SLOTS)) return MAX_SLOTS;
    return int'(slot_count_reg);
  endfunction

  function automatic logic [7:0] header_octet(input int off, input int n);
    logic [15:0] root_word;
    logic [15:0] frame_word;
    logic [15:0] dmp_word;
    logic [15:0] prop_word;
    logic [7:0]  octet;
    root_word  = LEN_FLAGS | 16'(n + 110);
    frame_word = LEN_FLAGS | 16'(n + 88);
    dmp_word   = LEN_FLAGS | 16'(n + 11);
    prop_word  = 16'(n + 1);
    octet      = 8'h00;
    if (off < 16) begin
      octet = ACN_PREAMBLE[off];
    end else begin
      case (off)
        16:  octet = root_word[15:8];
        17:  octet = root_word[7:0];
        21:  octet = 8'h04;
        38:  octet = frame_word[15:8];
        39:  octet = frame_word[7:0];
        43:  octet = 8'h02;
        108: octet = priority_reg;
        111: octet = seq_count;
        112: octet = preview_reg ? 8'h40 : 8'h00;
        113: octet = universe_reg[15:8];
        114: octet = universe_reg[7:0];
        115: octet = dmp_word[15:8];
        116: octet = dmp_word[7:0];
        117: octet = 8'h02;
        118: octet = 8'ha1;
        122: octet = 8'h01;
        123: octet = prop_word[15:8];
        124: octet = prop_word[7:0];
        125: octet = start_code_reg;
        default: octet = 8'h00;
      endcase
    end
    return octet;
  endfunction

  // apply one request to the packet image and return the response it gives
  function automatic framer_resp_t framer_response(input framer_req_t r);
    framer_resp_t res;
    int n;
    int plen;
    int s;
    int off;
    n    = carried_slots();
    plen = n + HEADER_LEN;
    s    = int'(r.slot_number);
    off  = int'(r.byte_offset);
    res.read_byte     = 8'h00;
    res.status        = STATUS_OK;
    res.packet_length = 10'(plen);
    case (r.op)
      e131_pkt_pkg::OP_WRITE_SLOT: begin
        if (s >= 1 && s <= n) slot_image[s - 1] = r.write_value[7:0];
        else res.status = STATUS_REJECT;
      end
      e131_pkt_pkg::OP_WRITE_PAIR: begin
        if (s >= 1 && s + 1 <= n) begin
          slot_image[s - 1] = r.write_value[15:8];
          slot_image[s]     = r.write_value[7:0];
        end else begin
          res.status = STATUS_REJECT;
        end
      end
      e131_pkt_pkg::OP_CLEAR: begin
        foreach (slot_image[i]) slot_image[i] = 8'h00;
      end
      e131_pkt_pkg::OP_ADV_SEQ: begin
        seq_count = seq_count + 8'd1;
      end
      e131_pkt_pkg::OP_READ: begin
        if (off < HEADER_LEN) res.read_byte = header_octet(off, n);
        else if (off < plen) res.read_byte = slot_image[off - HEADER_LEN];
        else res.status = STATUS_REJECT;
      end
      default: res.status = STATUS_REJECT;
    endcase
    return res;
  endfunction

  function automatic framer_req_t make_request(input logic [2:0] op, input int slot,
                                               input int value, input int offset);
    framer_req_t r;
    r.op          = op;
    r.slot_number = 10'(slot);
    r.write_value = 16'(value);
    r.byte_offset = 10'(offset);
    return r;
  endfunction

  function automatic framer_req_t random_request();
    framer_req_t r;
    int n;
    int pick;
    int spot;
    n = carried_slots();
    r.op          = OP_SPARE_5;
    r.slot_number = 10'($urandom);
    r.write_value = 16'($urandom);
    r.byte_offset = 10'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      r.op = e131_pkt_pkg::OP_READ;
      spot = $urandom_range(99);
      if (spot < 55) r.byte_offset = 10'($urandom_range(HEADER_LEN + n - 1, HEADER_LEN));
      else if (spot < 80) r.byte_offset = 10'($urandom_range(HEADER_LEN - 1, 0));
    end else if (pick < 65) begin
      r.op = e131_pkt_pkg::OP_WRITE_SLOT;
      if ($urandom_range(9) < 8) r.slot_number = 10'($urandom_range(n, 1));
    end else if (pick < 80) begin
      r.op = e131_pkt_pkg::OP_WRITE_PAIR;
      if (n > 1 && $urandom_range(9) < 8) r.slot_number = 10'($urandom_range(n - 1, 1));
    end else if (pick < 94) begin
      r.op = e131_pkt_pkg::OP_ADV_SEQ;
    end else if (pick < 95) begin
      r.op = e131_pkt_pkg::OP_CLEAR;
    end else begin
      case ($urandom_range(2))
        0: r.op = OP_SPARE_5;
        1: r.op = OP_SPARE_6;
        default: r.op = OP_SPARE_7;
      endcase
    end
    return r;
  endfunction

  task automatic issue_request(input framer_req_t r);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, r};
    do @(posedge clk); while (s_tready !== 1'b1);
    awaited.push_back(framer_response(r));
  endtask

  task automatic wait_until_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (CLEAR_SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [31:0] field,
                                input int width);
    logic [31:0] word;
    word = (32'($urandom) << width) | field;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (index)
      e131_pkt_pkg::REG_UNIVERSE: universe_reg   = field[15:0];
      e131_pkt_pkg::REG_PRIORITY: priority_reg   = field[7:0];
      e131_pkt_pkg::REG_START:    start_code_reg = field[7:0];
      e131_pkt_pkg::REG_SLOTS:    slot_count_reg = field[9:0];
      e131_pkt_pkg::REG_PREVIEW:  preview_reg    = field[0];
      default: ;
    endcase
  endtask

  task automatic program_registers(input int universe, input int prio, input int start,
                                   input int slots, input int preview);
    write_register(e131_pkt_pkg::REG_UNIVERSE, 32'(universe), 16);
    write_register(e131_pkt_pkg::REG_PRIORITY, 32'(prio), 8);
    write_register(e131_pkt_pkg::REG_START, 32'(start), 8);
    write_register(e131_pkt_pkg::REG_SLOTS, 32'(slots), 10);
    write_register(e131_pkt_pkg::REG_PREVIEW, 32'(preview), 1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_header_fields();
    int offsets [15] = '{4, 16, 17, 38, 39, 108, 112, 113, 114, 116, 123, 124, 125,
                         638, 1023};
    foreach (offsets[i]) begin
      issue_request(make_request(e131_pkt_pkg::OP_READ, $urandom, $urandom, offsets[i]));
    end
  endtask

  task automatic test_slot_operations();
    issue_request(make_request(e131_pkt_pkg::OP_WRITE_SLOT, 0, 16'h00ff, $urandom));
    issue_request(make_request(e131_pkt_pkg::OP_WRITE_SLOT, 1, 16'hffab, $urandom));
    issue_request(make_request(e131_pkt_pkg::OP_WRITE_SLOT, 512, 16'h0055, $urandom));
    issue_request(make_request(e131_pkt_pkg::OP_WRITE_SLOT, 513, 16'h1111, $urandom));
    issue_request(make_request(e131_pkt_pkg::OP_WRITE_PAIR, 511, 16'hbeef, $urandom));
    issue_request(make_request(e131_pkt_pkg::OP_WRITE_PAIR, 512, 16'h2222, $urandom));
    issue_request(make_request(e131_pkt_pkg::OP_READ, $urandom, $urandom, 636));
    issue_request(make_request(e131_pkt_pkg::OP_READ, $urandom, $urandom, 637));
    issue_request(make_request(e131_pkt_pkg::OP_ADV_SEQ, $urandom, $urandom, $urandom));
    issue_request(make_request(e131_pkt_pkg::OP_READ, $urandom, $urandom, 111));
    issue_request(make_request(e131_pkt_pkg::OP_CLEAR, $urandom, $urandom, $urandom));
    issue_request(make_request(e131_pkt_pkg::OP_READ, $urandom, $urandom, 637));
    issue_request(make_request(OP_SPARE_5, $urandom, $urandom, $urandom));
    issue_request(make_request(OP_SPARE_7, $urandom, $urandom, $urandom));
  endtask

  task automatic test_config_sweep();
    for (int phase = 0; phase < CONFIG_PHASES; phase++) begin
      wait_until_idle();
      case (phase)
        0: program_registers(0, 0, 0, 0, 0);
        1: program_registers(16'hffff, 8'hff, 8'hff, 10'h3ff, 1);
        2: program_registers($urandom_range(65535), $urandom_range(255),
                             $urandom_range(255), 2, 1);
        3: program_registers($urandom_range(65535), $urandom_range(255),
                             $urandom_range(255), $urandom_range(512, 1), 0);
        4: program_registers(1, 100, $urandom_range(255), 512, 0);
        default: program_registers($urandom_range(65535), $urandom_range(255),
                                   $urandom_range(255), $urandom_range(40, 3), 1);
      endcase
      case (phase / 2)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) issue_request(random_request());
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 300;
    repeat (40) issue_request(random_request());
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    framer_resp_t got;
    framer_resp_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got = m_tdata[18:0];
      if (awaited.size() == 0) begin
        $error("response with none outstanding: %h", m_tdata);
        error_count++;
      end else begin
        want = awaited.pop_front();
        if (got.read_byte !== want.read_byte) begin
          $error("read_byte: expected %0h, got %0h", want.read_byte, got.read_byte);
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0h, got %0h", want.status, got.status);
          error_count++;
        end
        if (got.packet_length !== want.packet_length) begin
          $error("packet_length: expected %0d, got %0d", want.packet_length,
                 got.packet_length);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    m_tready <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    universe_reg   = e131_pkt_pkg::RST_UNIVERSE;
    priority_reg   = e131_pkt_pkg::RST_PRIORITY;
    start_code_reg = e131_pkt_pkg::RST_START;
    slot_count_reg = e131_pkt_pkg::RST_SLOTS;
    preview_reg    = 1'b0;
    foreach (slot_image[i]) slot_image[i] = 8'h00;
    seq_count     = 8'h00;
    error_count   = 0;
    hold_cycles   = 0;
    quiet_cycles  = 0;
    send_idle_pct = 37;
    recv_idle_pct = 60;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait_until_idle();
    test_header_fields();
    test_slot_operations();
    test_config_sweep();
    test_backpressure();
    wait_until_idle();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/e131_pkt_pkg.sv
design/e131_pkt_front.sv
design/e131_pkt_cmdq.sv
design/e131_pkt_back.sv
design/e131_packet_buffer_framer_top.sv
bench/tb_e131_packet_buffer_framer_top.sv
